### design/owsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsc_pkg
// Shared types and constants for the omni wheel speed commander.
// ----------------------------------------------------------------------------
package owsc_pkg;

    // Coefficients in Q32, rounded to nearest at the chosen fraction width at elaboration
    localparam logic [63:0] Q32_COS  = 64'd2173398451;
    localparam logic [63:0] Q32_SIN  = 64'd3704468003;
    localparam logic [63:0] Q32_TURN = 64'd499742136;
    localparam logic [63:0] Q32_RPM  = 64'd26040581922;

    localparam int NUM_WHEELS  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int TOTAL_W     = 17;
    localparam int DIV_STEPS   = TOTAL_W;

    // wheel lanes: 0 left, 1 right, 2 rear
    localparam logic [1:0] WHEEL_LEFT  = 2'd0;
    localparam logic [1:0] WHEEL_RIGHT = 2'd1;
    localparam logic [1:0] WHEEL_REAR  = 2'd2;

    // drive unit ids
    localparam logic [1:0] UNIT_RIGHT = 2'd1;
    localparam logic [1:0] UNIT_LEFT  = 2'd2;
    localparam logic [1:0] UNIT_REAR  = 2'd3;

    // write phases
    localparam logic [1:0] PH_ACCEL = 2'd0;
    localparam logic [1:0] PH_DECEL = 2'd1;
    localparam logic [1:0] PH_SPEED = 2'd2;

    // register indexes
    localparam logic [2:0] REG_ACCEL_ADDR = 3'd0;
    localparam logic [2:0] REG_DECEL_ADDR = 3'd1;
    localparam logic [2:0] REG_SPEED_ADDR = 3'd2;
    localparam logic [2:0] REG_IDLE_RAMP  = 3'd3;
    localparam logic [2:0] REG_RAMP_SCALE = 3'd4;

    localparam logic [15:0] IDLE_RAMP_RST  = 16'd500;
    localparam logic [15:0] RAMP_SCALE_RST = 16'd250;

    typedef struct packed {
        logic [15:0] accel_addr;
        logic [15:0] decel_addr;
        logic [15:0] speed_addr;
        logic [15:0] idle_ramp;
        logic [15:0] ramp_scale;
    } cfg_t;

    typedef struct packed {
        logic [NUM_WHEELS-1:0][15:0] rpm;
        logic [NUM_WHEELS-1:0]       chg;
        logic [TOTAL_W-1:0]          total;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_SUM,
        F_SCALE,
        F_SAT,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_MUL,
        B_EMIT
    } back_state_t;

    function automatic logic [1:0] unit_of(input logic [1:0] wheel);
        logic [1:0] u;
        unique case (wheel)
            WHEEL_LEFT:  u = UNIT_LEFT;
            WHEEL_RIGHT: u = UNIT_RIGHT;
            default:     u = UNIT_REAR;
        endcase
        return u;
    endfunction

endpackage

### design/owsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsc_if
// Channel interfaces: body velocity tick in, drive register write out.
// ----------------------------------------------------------------------------
interface owsc_tick_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate;

    modport source (output valid, output vel_x, output vel_y, output turn_rate, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input turn_rate, output ready);
endinterface

interface owsc_write_if;
    logic        valid;
    logic        ready;
    logic [1:0]  unit_id;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
    logic        last_write;

    modport source (output valid, output unit_id, output reg_addr, output reg_value,
                    output last_write, input ready);
    modport sink   (input valid, input unit_id, input reg_addr, input reg_value,
                    input last_write, output ready);
endinterface

### design/owsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsc_front
// Takes a tick, works out the three wheel rpms, flags changed wheels and
// queues the job for the write sequencer.
// ----------------------------------------------------------------------------
module owsc_front #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    owsc_tick_if.sink            tick,
    input  logic                 q_full,
    output logic                 q_push,
    output owsc_pkg::job_t       q_data
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int CW = F + 3;
    localparam int PW = CW + 17;
    localparam int SW = PW + 2;
    localparam int WW = SW - F;
    localparam int MW = WW + CW + 1;
    localparam int RW = MW - F;

    localparam logic [63:0] C64 = (owsc_pkg::Q32_COS  + (64'd1 << (31 - F))) >> (32 - F);
    localparam logic [63:0] S64 = (owsc_pkg::Q32_SIN  + (64'd1 << (31 - F))) >> (32 - F);
    localparam logic [63:0] T64 = (owsc_pkg::Q32_TURN + (64'd1 << (31 - F))) >> (32 - F);
    localparam logic [63:0] K64 = (owsc_pkg::Q32_RPM  + (64'd1 << (31 - F))) >> (32 - F);
    localparam logic [CW-1:0] COEF_C = C64[CW-1:0];
    localparam logic [CW-1:0] COEF_S = S64[CW-1:0];
    localparam logic [CW-1:0] COEF_T = T64[CW-1:0];
    localparam logic [CW-1:0] COEF_K = K64[CW-1:0];

    localparam logic signed [RW-1:0] RPM_MAX = RW'(32'sd32767);
    localparam logic signed [RW-1:0] RPM_MIN = RW'(-32'sd32768);

    owsc_pkg::front_state_t state_reg, state_next;

    logic signed [15:0]   vx_reg, vy_reg, tr_reg;
    logic signed [PW-1:0] cx_reg, sy_reg, tt_reg;
    logic signed [WW-1:0] w_reg [owsc_pkg::NUM_WHEELS];
    logic signed [MW-1:0] y_reg [owsc_pkg::NUM_WHEELS];
    logic [15:0]          rpm_reg  [owsc_pkg::NUM_WHEELS];
    logic [15:0]          prev_reg [owsc_pkg::NUM_WHEELS];

    logic signed [SW-1:0] sum    [owsc_pkg::NUM_WHEELS];
    logic signed [SW-1:0] sum_sh [owsc_pkg::NUM_WHEELS];
    logic signed [WW-1:0] w_val  [owsc_pkg::NUM_WHEELS];
    logic signed [MW-1:0] y_sh   [owsc_pkg::NUM_WHEELS];
    logic signed [RW-1:0] r_val  [owsc_pkg::NUM_WHEELS];
    logic [15:0]          rpm_val[owsc_pkg::NUM_WHEELS];
    logic [15:0]          mag    [owsc_pkg::NUM_WHEELS];
    logic signed [SW-1:0] vx_ext;

    assign vx_ext = SW'(vx_reg);
    assign sum[0] = SW'(cx_reg) + SW'(sy_reg) - SW'(tt_reg);
    assign sum[1] = SW'(cx_reg) - SW'(sy_reg) - SW'(tt_reg);
    assign sum[2] = -(vx_ext <<< F) - SW'(tt_reg);

    // truncation toward zero on both divides by 2^F
    for (genvar i = 0; i < owsc_pkg::NUM_WHEELS; i++)
    begin : g_lane
        assign sum_sh[i] = sum[i] >>> F;
        assign w_val[i]  = sum_sh[i][WW-1:0]
                         + WW'(sum[i][SW-1] && (|sum[i][F-1:0]));
        assign y_sh[i]   = y_reg[i] >>> F;
        assign r_val[i]  = y_sh[i][RW-1:0]
                         + RW'(y_reg[i][MW-1] && (|y_reg[i][F-1:0]));
        always_comb
        begin
            if (r_val[i] > RPM_MAX)
                rpm_val[i] = 16'h7fff;
            else if (r_val[i] < RPM_MIN)
                rpm_val[i] = 16'h8000;
            else
                rpm_val[i] = r_val[i][15:0];
        end
        // -32768 negates to 0x8000, which is 32768 read unsigned
        assign mag[i] = rpm_reg[i][15] ? 16'(-rpm_reg[i]) : rpm_reg[i];
        assign q_data.rpm[i] = rpm_reg[i];
        assign q_data.chg[i] = rpm_reg[i] != prev_reg[i];
    end

    assign q_data.total = owsc_pkg::TOTAL_W'(mag[0]) + owsc_pkg::TOTAL_W'(mag[1])
                        + owsc_pkg::TOTAL_W'(mag[2]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            owsc_pkg::F_IDLE:  if (tick.valid) state_next = owsc_pkg::F_MUL;
            owsc_pkg::F_MUL:   state_next = owsc_pkg::F_SUM;
            owsc_pkg::F_SUM:   state_next = owsc_pkg::F_SCALE;
            owsc_pkg::F_SCALE: state_next = owsc_pkg::F_SAT;
            owsc_pkg::F_SAT:   state_next = owsc_pkg::F_PUSH;
            owsc_pkg::F_PUSH:  if (!q_full) state_next = owsc_pkg::F_IDLE;
            default:           state_next = owsc_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        tick.ready = (state_reg == owsc_pkg::F_IDLE);
        q_push     = (state_reg == owsc_pkg::F_PUSH) && !q_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= owsc_pkg::F_IDLE;
            for (int i = 0; i < owsc_pkg::NUM_WHEELS; i++)
                prev_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_push)
                for (int i = 0; i < owsc_pkg::NUM_WHEELS; i++)
                    prev_reg[i] <= rpm_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            vx_reg <= tick.vel_x;
            vy_reg <= tick.vel_y;
            tr_reg <= tick.turn_rate;
        end
        if (state_reg == owsc_pkg::F_MUL)
        begin
            cx_reg <= vx_reg * $signed({1'b0, COEF_C});
            sy_reg <= vy_reg * $signed({1'b0, COEF_S});
            tt_reg <= tr_reg * $signed({1'b0, COEF_T});
        end
        for (int i = 0; i < owsc_pkg::NUM_WHEELS; i++)
        begin
            if (state_reg == owsc_pkg::F_SUM)
                w_reg[i] <= w_val[i];
            if (state_reg == owsc_pkg::F_SCALE)
                y_reg[i] <= w_reg[i] * $signed({1'b0, COEF_K});
            if (state_reg == owsc_pkg::F_SAT)
                rpm_reg[i] <= rpm_val[i];
        end
    end

endmodule

### design/owsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsc_queue
// Short job queue between the kinematics front and the write sequencer.
// ----------------------------------------------------------------------------
module owsc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  owsc_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output owsc_pkg::job_t pop_data,
    output logic           empty
);

    localparam int DEPTH = owsc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    owsc_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### design/owsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsc_back
// Write sequencer: ramp times through a shared restoring divider, then the
// drive register writes in accel, decel, speed order.
// ----------------------------------------------------------------------------
module owsc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  owsc_pkg::cfg_t cfg,
    input  logic           q_empty,
    input  owsc_pkg::job_t q_data,
    output logic           q_pop,
    owsc_write_if.source   cmd
);

    localparam int TW    = owsc_pkg::TOTAL_W;
    localparam int STEPW = $clog2(owsc_pkg::DIV_STEPS);

    owsc_pkg::back_state_t state_reg, state_next;

    owsc_pkg::job_t   job_reg, job_next;
    logic [1:0]       wheel_reg, wheel_next;
    logic [STEPW-1:0] step_reg, step_next;
    logic [TW-1:0]    rem_reg, rem_next;
    logic [TW-1:0]    quo_reg, quo_next;
    logic [owsc_pkg::NUM_WHEELS-1:0][15:0] ramp_reg, ramp_next;
    logic [1:0]       ph_reg, ph_next;
    logic [1:0]       slot_reg, slot_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_unit_reg, out_unit_next;
    logic [15:0]      out_addr_reg, out_addr_next;
    logic [15:0]      out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;

    logic [15:0]      cur_rpm;
    logic [15:0]      cur_mag;
    logic [TW-1:0]    shifted;
    logic [TW:0]      trial;
    logic [31:0]      scaled;
    logic [1:0]       last_slot;
    logic             can_load;
    logic             div_done;

    assign cur_rpm  = job_reg.rpm[wheel_reg];
    assign cur_mag  = cur_rpm[15] ? 16'(-cur_rpm) : cur_rpm;
    assign shifted  = {rem_reg[TW-2:0], quo_reg[TW-1]};
    assign trial    = {1'b0, shifted} - (TW + 1)'(cur_mag);
    assign scaled   = quo_reg[15:0] * cfg.ramp_scale;
    assign can_load = !out_valid_reg || cmd.ready;
    assign div_done = (step_reg == STEPW'(owsc_pkg::DIV_STEPS - 1));

    always_comb
    begin
        priority if (job_reg.chg[owsc_pkg::WHEEL_REAR])
            last_slot = owsc_pkg::WHEEL_REAR;
        else if (job_reg.chg[owsc_pkg::WHEEL_RIGHT])
            last_slot = owsc_pkg::WHEEL_RIGHT;
        else
            last_slot = owsc_pkg::WHEEL_LEFT;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            owsc_pkg::B_IDLE:
                if (!q_empty && (|q_data.chg))
                    state_next = owsc_pkg::B_DIV;
            owsc_pkg::B_DIV:
                if (div_done)
                    state_next = owsc_pkg::B_MUL;
            owsc_pkg::B_MUL:
                state_next = (wheel_reg == owsc_pkg::WHEEL_REAR) ? owsc_pkg::B_EMIT
                                                                 : owsc_pkg::B_DIV;
            owsc_pkg::B_EMIT:
                if (can_load && ph_reg == owsc_pkg::PH_SPEED
                    && slot_reg == owsc_pkg::WHEEL_REAR)
                    state_next = owsc_pkg::B_IDLE;
            default:
                state_next = owsc_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        job_next       = job_reg;
        wheel_next     = wheel_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        ramp_next      = ramp_reg;
        ph_next        = ph_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !cmd.ready;
        out_unit_next  = out_unit_reg;
        out_addr_next  = out_addr_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            owsc_pkg::B_IDLE:
            begin
                // a job with no changed wheel is dropped without writes
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_data;
                    wheel_next = owsc_pkg::WHEEL_LEFT;
                    step_next  = '0;
                    rem_next   = '0;
                    quo_next   = q_data.total;
                end
            end
            owsc_pkg::B_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (!trial[TW])
                begin
                    rem_next = trial[TW-1:0];
                    quo_next = {quo_reg[TW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[TW-2:0], 1'b0};
                end
            end
            owsc_pkg::B_MUL:
            begin
                ramp_next[wheel_reg] = (cur_rpm == '0) ? cfg.idle_ramp : scaled[15:0];
                wheel_next = wheel_reg + 1'b1;
                step_next  = '0;
                rem_next   = '0;
                quo_next   = job_reg.total;
                ph_next    = owsc_pkg::PH_ACCEL;
                slot_next  = owsc_pkg::WHEEL_LEFT;
            end
            owsc_pkg::B_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = job_reg.chg[slot_reg];
                    out_unit_next  = owsc_pkg::unit_of(slot_reg);
                    unique case (ph_reg)
                        owsc_pkg::PH_ACCEL: out_addr_next = cfg.accel_addr;
                        owsc_pkg::PH_DECEL: out_addr_next = cfg.decel_addr;
                        default:            out_addr_next = cfg.speed_addr;
                    endcase
                    out_value_next = (ph_reg == owsc_pkg::PH_SPEED) ? job_reg.rpm[slot_reg]
                                                                    : ramp_reg[slot_reg];
                    out_last_next  = (ph_reg == owsc_pkg::PH_SPEED) && (slot_reg == last_slot);
                    if (slot_reg == owsc_pkg::WHEEL_REAR)
                    begin
                        slot_next = owsc_pkg::WHEEL_LEFT;
                        ph_next   = ph_reg + 1'b1;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign cmd.valid      = out_valid_reg;
    assign cmd.unit_id    = out_unit_reg;
    assign cmd.reg_addr   = out_addr_reg;
    assign cmd.reg_value  = out_value_reg;
    assign cmd.last_write = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= owsc_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            wheel_reg     <= '0;
            step_reg      <= '0;
            ph_reg        <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wheel_reg     <= wheel_next;
            step_reg      <= step_next;
            ph_reg        <= ph_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        ramp_reg      <= ramp_next;
        out_unit_reg  <= out_unit_next;
        out_addr_reg  <= out_addr_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

endmodule

### design/omni_wheel_speed_commander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_speed_commander
// Three-wheel omni base inverse kinematics that turns body velocity ticks
// into drive register writes for the wheels whose rpm changed.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | word
//  tick    | in  | valid / ready     | vel_x, vel_y, turn_rate
//  cmd     | out | valid / ready     | unit_id, reg_addr, reg_value, last_write
//  apb     | in  | psel / penable    | paddr, pwdata, prdata (5 x 16-bit regs)
//
// Front: per tick it steps through capture, products, sums, rpm scale, saturate, queue.
// Back: a load step, then the three ramp divisions (17-step restoring divider
// plus a scale multiply each), then 9 write slots, one per cycle when cmd
// is ready.
// A 2-deep job queue lets the front take ticks while writes are stalled.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module omni_wheel_speed_commander #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    owsc_tick_if.sink    tick,
    owsc_write_if.source cmd,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    owsc_pkg::cfg_t cfg_reg, cfg_next;
    owsc_pkg::job_t push_data, pop_data;
    logic           q_push, q_pop, q_full, q_empty;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                owsc_pkg::REG_ACCEL_ADDR: cfg_next.accel_addr = pwdata[15:0];
                owsc_pkg::REG_DECEL_ADDR: cfg_next.decel_addr = pwdata[15:0];
                owsc_pkg::REG_SPEED_ADDR: cfg_next.speed_addr = pwdata[15:0];
                owsc_pkg::REG_IDLE_RAMP:  cfg_next.idle_ramp  = pwdata[15:0];
                owsc_pkg::REG_RAMP_SCALE: cfg_next.ramp_scale = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            owsc_pkg::REG_ACCEL_ADDR: prdata = {16'd0, cfg_reg.accel_addr};
            owsc_pkg::REG_DECEL_ADDR: prdata = {16'd0, cfg_reg.decel_addr};
            owsc_pkg::REG_SPEED_ADDR: prdata = {16'd0, cfg_reg.speed_addr};
            owsc_pkg::REG_IDLE_RAMP:  prdata = {16'd0, cfg_reg.idle_ramp};
            owsc_pkg::REG_RAMP_SCALE: prdata = {16'd0, cfg_reg.ramp_scale};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_addr <= '0;
            cfg_reg.decel_addr <= '0;
            cfg_reg.speed_addr <= '0;
            cfg_reg.idle_ramp  <= owsc_pkg::IDLE_RAMP_RST;
            cfg_reg.ramp_scale <= owsc_pkg::RAMP_SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    owsc_front #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (push_data)
    );

    owsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    owsc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .q_pop   (q_pop),
        .cmd     (cmd)
    );

endmodule
